// ----- design/nca_pkg.sv -----
// Shared constants, codes and control structs for the nearest centre assignment block.
`default_nettype none

package nca_pkg;

	// Store geometry.
	localparam int K_MAX = 64;
	localparam int D_MAX = 16;

	// Field widths.
	localparam int CI_W   = 6;
	localparam int DI_W   = 4;
	localparam int ADDR_W = CI_W + DI_W;
	localparam int VAL_W  = 32;
	localparam int SUM_W  = 64;
	localparam int PN_W   = 32;
	localparam int KC_W   = 7;
	localparam int DC_W   = 5;

	// Stream and configuration port widths.
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 104;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DAT_W   = 7;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CENTRES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIMS    = 2'd1;

	// Item kinds carried on tuser.
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_POINT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic            store_wr;
		logic            capture;
		logic            issue;
		logic [CI_W-1:0] issue_c;
		logic            finish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic busy;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// ----- design/nca_ctrl.sv -----
// Controller state machine: configuration registers and sequencing of the centre sweep.
`default_nettype none

module nca_ctrl import nca_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic                 kind,
	input  wire logic [DI_W-1:0]      coord_index,
	input  wire sts_t                 sts,
	output cmd_t                      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t          state_q;
	logic [CI_W-1:0] cnt_q;
	logic            last_q;
	logic [KC_W-1:0] centres_q;
	logic [DC_W-1:0] dims_q;
	logic [KC_W-1:0] k_eff;
	logic [DC_W-1:0] d_eff;
	logic            point_ok;
	logic            cnt_end;

	// Effective register values: zero acts as one, large values clamp to the maximum.
	always_comb begin
		if (centres_q == '0) begin
			k_eff = KC_W'(1);
		end else if (centres_q > KC_W'(K_MAX)) begin
			k_eff = KC_W'(K_MAX);
		end else begin
			k_eff = centres_q;
		end
		if (dims_q == '0) begin
			d_eff = DC_W'(1);
		end else if (dims_q > DC_W'(D_MAX)) begin
			d_eff = DC_W'(D_MAX);
		end else begin
			d_eff = dims_q;
		end
	end

	// A point coordinate beyond the dimensions in use is dropped.
	assign point_ok = ({1'b0, coord_index} < d_eff);
	assign cnt_end  = ({1'b0, cnt_q} == (k_eff - KC_W'(1)));

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);

	// Commands to the datapath.
	always_comb begin
		cmd.store_wr = (state_q == ST_IDLE) && s_tvalid && (kind == KIND_LOAD);
		cmd.capture  = (state_q == ST_IDLE) && s_tvalid && (kind == KIND_POINT) && point_ok;
		cmd.issue    = (state_q == ST_RUN);
		cmd.issue_c  = cnt_q;
		cmd.finish   = (state_q == ST_FINISH) && sts.out_free;
	end

	// State, sweep counter, last-coordinate flag and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			last_q    <= 1'b0;
			centres_q <= KC_W'(1);
			dims_q    <= DC_W'(1);
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_CENTRES: centres_q <= cfg_data[KC_W-1:0];
					REG_DIMS:    dims_q    <= cfg_data[DC_W-1:0];
					default:     ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.capture) begin
						cnt_q   <= '0;
						last_q  <= ({1'b0, coord_index} == (d_eff - DC_W'(1)));
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + CI_W'(1);
					if (cnt_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!sts.busy) begin
						state_q <= last_q ? ST_FINISH : ST_IDLE;
					end
				end
				ST_FINISH: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- design/nca_datapath.sv -----
// Datapath: centre store, running sums, squaring pipeline, minimum search and result register.
`default_nettype none

module nca_datapath import nca_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cmd_t                    cmd,
	output sts_t                         sts,
	input  wire logic [CI_W-1:0]         centre_index,
	input  wire logic [DI_W-1:0]         coord_index,
	input  wire logic [VAL_W-1:0]        value,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [PN_W-1:0]              point_number,
	output logic [CI_W-1:0]              nearest_centre,
	output logic [SUM_W-1:0]             min_distance
);

	// Storage.
	logic [VAL_W-1:0] centre_mem [K_MAX*D_MAX];
	logic [SUM_W-1:0] sum_mem [K_MAX];
	logic [K_MAX-1:0] sum_vld_q;

	// Held point coordinate.
	logic [VAL_W-1:0] val_q;
	logic [DI_W-1:0]  di_q;

	// Pipeline registers.
	logic             v_s1, v_s2, v_s3;
	logic [CI_W-1:0]  c_s1, c_s2, c_s3;
	logic [VAL_W-1:0] cdat_s1;
	logic [SUM_W-1:0] sum_s1, sum_s2, sum_s3;
	logic             svld_s1;
	logic [VAL_W-1:0] mag_s2;
	logic [SUM_W-1:0] sq_s3;

	// Running minimum, point counter and result register.
	logic [SUM_W-1:0] best_d_q;
	logic [CI_W-1:0]  best_c_q;
	logic [PN_W-1:0]  pcnt_q;
	logic             out_valid_q;
	logic [PN_W-1:0]  out_pn_q;
	logic [CI_W-1:0]  out_c_q;
	logic [SUM_W-1:0] out_d_q;

	logic signed [VAL_W:0] diff;
	logic [VAL_W:0]        diff_abs;
	logic [SUM_W:0]        acc_wide;
	logic [SUM_W-1:0]      acc_sat;
	logic [SUM_W-1:0]      sum_in;

	// Hold the point coordinate for the sweep over centres.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			val_q <= value;
			di_q  <= coord_index;
		end
	end

	// Centre store: written by load transactions, read once per centre in the sweep.
	always_ff @(posedge clk) begin
		if (cmd.store_wr) begin
			centre_mem[{centre_index, coord_index}] <= value;
		end
		if (cmd.issue) begin
			cdat_s1 <= centre_mem[{cmd.issue_c, di_q}];
			sum_s1  <= sum_mem[cmd.issue_c];
			svld_s1 <= sum_vld_q[cmd.issue_c];
			c_s1    <= cmd.issue_c;
		end
		if (v_s3) begin
			sum_mem[c_s3] <= acc_sat;
		end
	end

	// Valid bits of the running sums: a sum that is not valid reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_vld_q <= '0;
		end else if (cmd.finish) begin
			sum_vld_q <= '0;
		end else if (v_s3) begin
			sum_vld_q[c_s3] <= 1'b1;
		end
	end

	// Stage 2: magnitude of the difference, which always fits in 32 bits.
	assign sum_in   = svld_s1 ? sum_s1 : '0;
	assign diff     = $signed({val_q[VAL_W-1], val_q}) - $signed({cdat_s1[VAL_W-1], cdat_s1});
	assign diff_abs = diff[VAL_W] ? (VAL_W+1)'(-diff) : diff;

	always_ff @(posedge clk) begin
		mag_s2 <= diff_abs[VAL_W-1:0];
		sum_s2 <= sum_in;
		c_s2   <= c_s1;
	end

	// Stage 3: square of the magnitude.
	always_ff @(posedge clk) begin
		sq_s3  <= SUM_W'(mag_s2) * SUM_W'(mag_s2);
		sum_s3 <= sum_s2;
		c_s3   <= c_s2;
	end

	// Stage 4: saturating accumulate.
	assign acc_wide = {1'b0, sum_s3} + {1'b0, sq_s3};
	assign acc_sat  = acc_wide[SUM_W] ? '1 : acc_wide[SUM_W-1:0];

	// Pipeline valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Running minimum in centre order; strict compare keeps the first on ties.
	always_ff @(posedge clk) begin
		if (v_s3 && ((c_s3 == '0) || (acc_sat < best_d_q))) begin
			best_d_q <= acc_sat;
			best_c_q <= c_s3;
		end
	end

	// Point counter and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			pcnt_q      <= pcnt_q + PN_W'(1);
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_pn_q <= pcnt_q;
			out_c_q  <= best_c_q;
			out_d_q  <= best_d_q;
		end
	end

	assign sts.busy       = v_s1 || v_s2 || v_s3;
	assign sts.out_free   = !out_valid_q || out_ready;
	assign out_valid      = out_valid_q;
	assign point_number   = out_pn_q;
	assign nearest_centre = out_c_q;
	assign min_distance   = out_d_q;

	// The result is only taken once every sum of the point has been written back.
	a_finish_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(v_s1 || v_s2 || v_s3))
		else $error("result taken while the squaring pipeline is busy");

	// A centre load never overlaps the sweep over centres.
	a_no_load_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> !cmd.store_wr && !cmd.capture)
		else $error("store write or capture during the centre sweep");

	// Finishing a point always presents a result in the next cycle.
	a_finish_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q && (pcnt_q == $past(pcnt_q) + PN_W'(1)))
		else $error("finished point did not produce a result");

endmodule

`default_nettype wire

// ----- design/nearest_centre_assign.sv -----
// A centre load transaction is written to the store when it is accepted; a point coordinate, once
// taken, holds the input off while the centres in use pass one after another through the shared
// 32x32 squarer and while its pipeline drains. The last coordinate then also posts the result,
// which waits while an earlier result has not yet been taken.
// Reset clears the running sums (through valid bits), the point counter and both registers
// to 1; the centre store is not cleared and must be loaded before use.
`default_nettype none

module nearest_centre_assign import nca_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DAT_W-1:0]    cfg_data,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	input  wire logic [IN_TDATA_W-1:0]   s_tdata,   // centre_index[5:0], coord_index[9:6],
	                                                // value[41:10]
	input  wire logic                    s_tuser,   // kind[0]
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic [OUT_TDATA_W-1:0]       m_tdata    // point_number[31:0], nearest_centre[37:32],
	                                                // min_distance[101:38]
);

	cmd_t             cmd;
	sts_t             sts;
	logic [CI_W-1:0]  centre_index;
	logic [DI_W-1:0]  coord_index;
	logic [VAL_W-1:0] value;
	logic [PN_W-1:0]  point_number;
	logic [CI_W-1:0]  nearest_centre;
	logic [SUM_W-1:0] min_distance;

	// Unpack the input stream.
	assign centre_index = s_tdata[CI_W-1:0];
	assign coord_index  = s_tdata[CI_W+DI_W-1:CI_W];
	assign value        = s_tdata[ADDR_W+VAL_W-1:ADDR_W];

	nca_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.kind        (s_tuser),
		.coord_index (coord_index),
		.sts         (sts),
		.cmd         (cmd)
	);

	nca_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.centre_index   (centre_index),
		.coord_index    (coord_index),
		.value          (value),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.point_number   (point_number),
		.nearest_centre (nearest_centre),
		.min_distance   (min_distance)
	);

	// Pack the result stream, zero filled to whole bytes.
	assign m_tdata = {(OUT_TDATA_W-PN_W-CI_W-SUM_W)'(0), min_distance, nearest_centre,
		point_number};

endmodule

`default_nettype wire
